// ===== src/oed_pkg.sv =====
// ---------------------------------------------------------------------------
// oed_pkg: shared types and constants for the octal escape decoder
// Request payloads, the burst descriptor passed from front to back, and the
// character codes the front end classifies against.
// ---------------------------------------------------------------------------
package oed_pkg;

    localparam logic [7:0] BACKSLASH_CODE = 8'h5C;
    localparam logic [7:0] DIGIT_ZERO     = 8'h30;
    localparam logic [7:0] DIGIT_SEVEN    = 8'h37;

    // Most bytes one input request can produce
    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned BURST_IW  = $clog2(BURST_MAX);

    // Entries in the front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       token_end;
    } out_t;

    // Output bytes produced by one input request
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_IW-1:0]       last_idx;
        logic                      tok_last;
    } burst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== src/oed_front.sv =====
// ---------------------------------------------------------------------------
// oed_front: request intake and escape classification
// Tracks the held escape prefix and turns each input byte into a burst of
// zero to four output bytes, pushed to the queue when non-empty.
// ---------------------------------------------------------------------------
module oed_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oed_pkg::in_t        s_data,
    input  oed_pkg::q_stat_t    q_stat,
    output logic                push,
    output oed_pkg::burst_t     push_data
);

    logic [1:0] held_reg, held_next;
    logic [2:0] d1_reg, d1_next;
    logic [2:0] d2_reg, d2_next;

    logic                                     accept;
    logic                                     is_oct;
    logic [2:0]                               dig;
    logic [7:0]                               dec_val;
    logic [oed_pkg::BURST_MAX-1:0][7:0]       bytes;
    logic [2:0]                               n;
    logic [1:0]                               h;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign is_oct  = (s_data.in_byte >= oed_pkg::DIGIT_ZERO) &&
                     (s_data.in_byte <= oed_pkg::DIGIT_SEVEN);
    assign dig     = s_data.in_byte[2:0];
    // d1*64 keeps only two bits of d1 inside 8 bits
    assign dec_val = {d1_reg[1:0], 6'b0} + {2'b0, d2_reg, 3'b0} + {5'b0, dig};

    always_comb begin
        bytes   = '0;
        n       = 3'd0;
        h       = held_reg;
        d1_next = d1_reg;
        d2_next = d2_reg;

        if (h != 2'd0 && is_oct) begin
            if (h == 2'd1) begin
                d1_next = dig;
                h       = 2'd2;
            end else if (h == 2'd2) begin
                d2_next = dig;
                h       = 2'd3;
            end else begin
                bytes[n[1:0]] = dec_val;
                n             = n + 3'd1;
                h             = 2'd0;
            end
        end else begin
            // broken escape: held bytes go out literally
            if (h >= 2'd1) begin
                bytes[n[1:0]] = oed_pkg::BACKSLASH_CODE;
                n             = n + 3'd1;
            end
            if (h >= 2'd2) begin
                bytes[n[1:0]] = oed_pkg::DIGIT_ZERO | {5'b0, d1_reg};
                n             = n + 3'd1;
            end
            if (h >= 2'd3) begin
                bytes[n[1:0]] = oed_pkg::DIGIT_ZERO | {5'b0, d2_reg};
                n             = n + 3'd1;
            end
            if (s_data.in_byte == oed_pkg::BACKSLASH_CODE) begin
                h = 2'd1;
            end else begin
                bytes[n[1:0]] = s_data.in_byte;
                n             = n + 3'd1;
                h             = 2'd0;
            end
        end

        // token end flushes whatever is still held
        if (s_data.in_last) begin
            if (h >= 2'd1) begin
                bytes[n[1:0]] = oed_pkg::BACKSLASH_CODE;
                n             = n + 3'd1;
            end
            if (h >= 2'd2) begin
                bytes[n[1:0]] = oed_pkg::DIGIT_ZERO | {5'b0, d1_next};
                n             = n + 3'd1;
            end
            if (h >= 2'd3) begin
                bytes[n[1:0]] = oed_pkg::DIGIT_ZERO | {5'b0, d2_next};
                n             = n + 3'd1;
            end
            h = 2'd0;
        end

        held_next          = accept ? h : held_reg;
        push               = accept && (n != 3'd0);
        push_data.bytes    = bytes;
        push_data.last_idx = n[1:0] - 2'd1;
        push_data.tok_last = s_data.in_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 2'd0;
        end else begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= 3'd0;
            d2_reg <= 3'd0;
        end else if (accept) begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
        end
    end

endmodule

// ===== src/oed_queue.sv =====
// ---------------------------------------------------------------------------
// oed_queue: burst queue between front and back
// Small circular buffer of burst descriptors; decouples intake from output.
// ---------------------------------------------------------------------------
module oed_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  oed_pkg::burst_t     push_data,
    input  logic                pop,
    output oed_pkg::burst_t     head,
    output oed_pkg::q_stat_t    q_stat
);

    localparam int unsigned AW = oed_pkg::QUEUE_AW;

    oed_pkg::burst_t   entry_reg [oed_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == (AW+1)'(oed_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/oed_back.sv =====
// ---------------------------------------------------------------------------
// oed_back: burst serializer and output register
// Walks the head burst into the output register, one byte per unstalled cycle.
// ---------------------------------------------------------------------------
module oed_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  oed_pkg::burst_t     head,
    input  oed_pkg::q_stat_t    q_stat,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output oed_pkg::out_t       m_data
);

    localparam int unsigned IW = oed_pkg::BURST_IW;

    logic [IW-1:0]                idx_reg, idx_next;
    logic                         valid_reg, valid_next;
    oed_pkg::out_t                data_reg;
    logic                         load;
    logic                         at_end;

    assign at_end  = (idx_reg == head.last_idx);
    // output slot free or being drained this cycle
    assign load    = !q_stat.empty && (!valid_reg || m_ready);
    assign pop     = load && at_end;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = at_end ? '0 : idx_reg + IW'(1);
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.out_byte  <= head.bytes[idx_reg];
            data_reg.run_last  <= at_end;
            data_reg.token_end <= at_end && head.tok_last;
        end
    end

endmodule

// ===== src/octal_escape_decoder.sv =====
// ---------------------------------------------------------------------------
// octal_escape_decoder: backslash octal escape decoder
// Turns a backslash and three octal digits into one byte, passes other bytes
// through and flushes broken or truncated escapes literally.
// ---------------------------------------------------------------------------
//  channel | ports                      | payload
//  --------+----------------------------+-----------------------------------
//  input   | s_valid s_ready s_data     | in_byte, in_last
//  result  | m_valid m_ready m_data     | out_byte, run_last, token_end
//
// One input byte is taken per cycle; it yields zero to four result bytes.
// The back end sends one result per cycle while m_ready is high, from the
// head of a two-entry burst queue; a result reaches m_valid at the earliest
// once its burst is written to the queue and then to the output register.
// Input stalls only when the queue is full (long bursts or a held m_ready).
// Reset is synchronous; it empties the queue and drops any held escape.
// ---------------------------------------------------------------------------
module octal_escape_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  oed_pkg::in_t     s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output oed_pkg::out_t    m_data
);

    logic              push;
    logic              pop;
    oed_pkg::burst_t   push_data;
    oed_pkg::burst_t   head;
    oed_pkg::q_stat_t  q_stat;

    oed_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    oed_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    oed_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a token's final result always closes its input's run
    a_tok_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_end |-> m_data.run_last)
        else $error("token_end without run_last");

    // the final byte of a token always produces a burst
    a_last_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.in_last |-> push)
        else $error("token end produced no output");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

// ===== verif/tb_octal_escape_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_octal_escape_decoder: self-checking bench for the octal escape decoder
// Drives tokens of plain bytes, full, broken and truncated escapes through the
// input channel, predicts the decoded stream per accepted request and checks
// every result field in order. Both sides idle at random; the receiver also
// holds off for a long stretch and the sender drains once mid-run.
// ---------------------------------------------------------------------------
module tb_octal_escape_decoder;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned IDLE_PCT     = 25;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned FIRST_WEIGHT = 64;
    // sender never idles while accepted count is in this window
    localparam int unsigned SEND_BUSY_LO = 200;
    localparam int unsigned SEND_BUSY_HI = 300;
    // receiver never stalls while result count is in this window
    localparam int unsigned RECV_BUSY_LO = 250;
    localparam int unsigned RECV_BUSY_HI = 350;
    localparam int unsigned HOLD_AT      = 120;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_AT     = 400;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    oed_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    oed_pkg::out_t m_data;

    oed_pkg::in_t  req_q[$];
    oed_pkg::out_t decoded_q[$];
    oed_pkg::out_t burst_q[$];

    logic [1:0] held_cnt;
    logic [2:0] dig_hi;
    logic [2:0] dig_mid;

    int unsigned sent_count  = 0;
    int unsigned recv_count  = 0;
    int unsigned error_count = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned cyc_count   = 0;

    octal_escape_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    always @(posedge aclk) cyc_count <= cyc_count + 1;

    // ---------------- prediction ----------------
    function automatic bit is_octal(logic [7:0] b);
        return (b >= oed_pkg::DIGIT_ZERO) && (b <= oed_pkg::DIGIT_SEVEN);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        oed_pkg::out_t r;
        r.out_byte  = b;
        r.run_last  = 1'b0;
        r.token_end = 1'b0;
        burst_q.insert(burst_q.size(), r);
    endfunction

    function automatic void flush_escape();
        if (held_cnt >= 2'd1) emit_byte(oed_pkg::BACKSLASH_CODE);
        if (held_cnt >= 2'd2) emit_byte(oed_pkg::DIGIT_ZERO + {5'd0, dig_hi});
        if (held_cnt >= 2'd3) emit_byte(oed_pkg::DIGIT_ZERO + {5'd0, dig_mid});
        held_cnt = 2'd0;
    endfunction

    function automatic void predict_decode(oed_pkg::in_t req);
        logic [2:0]  d;
        int unsigned value;
        burst_q.delete();
        if (held_cnt != 2'd0 && is_octal(req.in_byte)) begin
            d = 3'(req.in_byte - oed_pkg::DIGIT_ZERO);
            case (held_cnt)
                2'd1: begin
                    dig_hi   = d;
                    held_cnt = 2'd2;
                end
                2'd2: begin
                    dig_mid  = d;
                    held_cnt = 2'd3;
                end
                default: begin
                    value = dig_hi * FIRST_WEIGHT + dig_mid * 8 + d;
                    emit_byte(8'(value));
                    held_cnt = 2'd0;
                end
            endcase
        end else begin
            flush_escape();
            if (req.in_byte == oed_pkg::BACKSLASH_CODE) held_cnt = 2'd1;
            else emit_byte(req.in_byte);
        end
        if (req.in_last) flush_escape();
        if (burst_q.size() > 0) begin
            burst_q[$].run_last  = 1'b1;
            burst_q[$].token_end = req.in_last;
        end
        foreach (burst_q[i]) decoded_q.insert(decoded_q.size(), burst_q[i]);
    endfunction

    // ---------------- stimulus ----------------
    function automatic void push_req(logic [7:0] b, logic last);
        oed_pkg::in_t r;
        r.in_byte = b;
        r.in_last = last;
        req_q.insert(req_q.size(), r);
    endfunction

    function automatic void push_token(logic [7:0] tok[$]);
        foreach (tok[i]) push_req(tok[i], i == tok.size() - 1);
    endfunction

    function automatic logic [7:0] rand_digit();
        return oed_pkg::DIGIT_ZERO + 8'($urandom_range(0, 7));
    endfunction

    task automatic build_stimulus();
        logic [7:0]  tok[$];
        int unsigned segs;
        int unsigned kind;
        int unsigned ndig;
        int unsigned target;
        // extremes of the byte range
        push_token('{8'h00, 8'hFF});
        // value above 255 wraps, then an escape that decodes to zero
        push_token('{oed_pkg::BACKSLASH_CODE, "7", "7", "7",
                     oed_pkg::BACKSLASH_CODE, "4", "0", "0"});
        // escape broken by a non-digit
        push_req(oed_pkg::BACKSLASH_CODE, 1'b0);
        push_req("1", 1'b0);
        push_req("x", 1'b0);
        // escape broken by a new backslash, which then completes
        push_token('{oed_pkg::BACKSLASH_CODE, "1", "2",
                     oed_pkg::BACKSLASH_CODE, "0", "0", "7"});
        // token ends with bytes held
        push_token('{oed_pkg::BACKSLASH_CODE});
        push_token('{oed_pkg::BACKSLASH_CODE, "5", "6"});
        // broken escape on the final byte: four results from one request
        push_token('{oed_pkg::BACKSLASH_CODE, "1", "2", "A"});

        target = RANDOM_ITEMS;
        while (req_q.size() < target) begin
            tok.delete();
            segs = $urandom_range(1, 5);
            repeat (segs) begin
                kind = $urandom_range(0, 9);
                if (kind <= 2) begin
                    tok.insert(tok.size(), 8'($urandom_range(0, 255)));
                end else if (kind <= 5) begin
                    tok.insert(tok.size(), oed_pkg::BACKSLASH_CODE);
                    repeat (3) tok.insert(tok.size(), rand_digit());
                end else if (kind <= 7) begin
                    tok.insert(tok.size(), oed_pkg::BACKSLASH_CODE);
                    ndig = $urandom_range(0, 2);
                    repeat (ndig) tok.insert(tok.size(), rand_digit());
                    if ($urandom_range(0, 1))
                        tok.insert(tok.size(), 8'($urandom_range(0, 255)));
                end else if (kind == 8) begin
                    tok.insert(tok.size(), rand_digit());
                end else begin
                    // bytes right at the edges of the digit range
                    case ($urandom_range(0, 4))
                        0: tok.insert(tok.size(), oed_pkg::BACKSLASH_CODE);
                        1: tok.insert(tok.size(), oed_pkg::DIGIT_ZERO - 8'd1);
                        2: tok.insert(tok.size(), oed_pkg::DIGIT_SEVEN + 8'd1);
                        3: tok.insert(tok.size(), oed_pkg::DIGIT_SEVEN + 8'd2);
                        default: tok.insert(tok.size(), 8'hDC);
                    endcase
                end
            end
            push_token(tok);
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin : drive_blk
        bit busy;
        bit idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                predict_decode(s_data);
                sent_count++;
                busy = 1'b0;
            end
            if (!busy) begin
                idle = ($urandom_range(0, 99) < IDLE_PCT) &&
                       !(sent_count >= SEND_BUSY_LO && sent_count < SEND_BUSY_HI);
                // one drain: hold the next request until the pipe is empty
                if (sent_count == DRAIN_AT && decoded_q.size() != 0) idle = 1'b1;
                if (req_q.size() > 0 && !idle) begin
                    s_data  <= req_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin : watch_blk
        oed_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h", m_data.out_byte);
                    error_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, m_data.out_byte);
                        error_count++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, m_data.run_last);
                        error_count++;
                    end
                    if (m_data.token_end !== want.token_end) begin
                        $error("token_end: expected %0b, got %0b",
                               want.token_end, m_data.token_end);
                        error_count++;
                    end
                end
                recv_count++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_count == HOLD_AT && !hold_done) begin
                // long back-pressure so the burst queue fills
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready  <= 1'b0;
            end else if (recv_count >= RECV_BUSY_LO && recv_count < RECV_BUSY_HI) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------- sequencing ----------------
    initial begin
        held_cnt = 2'd0;
        dig_hi   = 3'd0;
        dig_mid  = 3'd0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        while (req_q.size() != 0 || s_valid) @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_octal_escape_decoder: clean");
        end else begin
            $display("tb_octal_escape_decoder: errors");
        end
        $finish;
    end

    initial begin
        wait (cyc_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles", cyc_count);
        $display("tb_octal_escape_decoder: errors");
        $finish;
    end

endmodule
